>>> design/epc_pkg.sv
// Shared types, constants and fixed-point helpers for the epipolar point correction block.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package epc_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned AW        = 130;  // accumulator width for sums of products
  localparam int unsigned SQ_STEPS  = 63;   // one root bit per stage
  localparam int unsigned DIV_STEPS = 62;   // one quotient bit per stage
  localparam int unsigned NPR       = 10;   // product slots carried between stages

  localparam logic signed [63:0] SAT_LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] NEG_LIM  = -64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] COORD_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] COORD_LO = -64'sh0000_0000_8000_0000;

  localparam logic [2:0] REG_PAIR_A = 3'd0;
  localparam logic [2:0] REG_PAIR_B = 3'd1;
  localparam logic [2:0] REG_PAIR_C = 3'd2;
  localparam logic [2:0] REG_PAIR_D = 3'd3;
  localparam logic [2:0] REG_LAST   = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] left_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] right_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] fixed_left_x;
    logic signed [COORD_W-1:0] fixed_left_y;
    logic signed [COORD_W-1:0] fixed_right_x;
    logic signed [COORD_W-1:0] fixed_right_y;
    logic                      status;
  } out_item_t;

  // matrix entries, row major
  typedef logic [8:0][31:0] mat_t;

  // working set of one item as it moves down the pipe
  typedef struct packed {
    logic signed [63:0] x1, y1, x2, y2;
    logic signed [63:0] q0, q1, q2, n20, n21;
    logic signed [63:0] qc, tv0, tv1, qb, qa, root, s;
    logic signed [63:0] dx10, dx11, dx20, dx21;
    logic signed [63:0] m10, m11, m20, m21, den2, s2;
    logic [NPR-1:0][3:0][63:0] pp;  // four partial products per slot
    logic signed [127:0] disc;
    logic signed [127:0] dnum;
    logic signed [63:0]  dden;
    logic                pass;
  } ctx_t;

  // 64x64 product as four 33x33 partial products: low halves unsigned, high halves signed
  function automatic logic [3:0][63:0] mul_pp(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [32:0] al, ah, bl, bh;
    logic signed [65:0] t0, t1, t2, t3;
    logic [3:0][63:0] p;
    al = {1'b0, a[31:0]};
    ah = {a[63], a[63:32]};
    bl = {1'b0, b[31:0]};
    bh = {b[63], b[63:32]};
    t0 = al * bl;
    t1 = ah * bl;
    t2 = al * bh;
    t3 = ah * bh;
    p[0] = t0[63:0];
    p[1] = t1[63:0];
    p[2] = t2[63:0];
    p[3] = t3[63:0];
    return p;
  endfunction

  function automatic logic signed [127:0] join_pp(input logic [3:0][63:0] p);
    logic signed [127:0] t0, t1, t2, t3;
    t0 = {64'd0, p[0]};
    t1 = 128'($signed(p[1]));
    t2 = 128'($signed(p[2]));
    t3 = 128'($signed(p[3]));
    return t0 + (t1 <<< 32) + (t2 <<< 32) + (t3 <<< 64);
  endfunction

  function automatic logic signed [AW-1:0] wid(input logic signed [127:0] p);
    logic signed [AW-1:0] t;
    t = p;
    return t;
  endfunction

  function automatic logic signed [AW-1:0] shl(input logic signed [63:0] v, input int sh);
    logic signed [AW-1:0] t;
    t = v;
    return t <<< sh;
  endfunction

  // add half an LSB, floor, saturate to +-(2^62-1)
  function automatic logic signed [63:0] rnd(input logic signed [AW-1:0] x, input int sh);
    logic signed [AW-1:0] h, t;
    h = '0;
    h[sh-1] = 1'b1;
    t = (x + h) >>> sh;
    if (t > SAT_LIM) return SAT_LIM;
    if (t < NEG_LIM) return NEG_LIM;
    return t[63:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [63:0] v);
    if (v > COORD_HI) return COORD_HI[COORD_W-1:0];
    if (v < COORD_LO) return COORD_LO[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/epc_stages.sv
// A run of arithmetic pipeline stages; stage numbers select the step of the correction.
// Depends on epc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epc_stages #(
  parameter int FIRST     = 0,
  parameter int COUNT     = 1,
  parameter int FRAC_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  epc_pkg::ctx_t din,
  input  epc_pkg::mat_t mat,
  output logic          vout,
  output epc_pkg::ctx_t dout
);

  function automatic epc_pkg::ctx_t step(input int k, input epc_pkg::ctx_t c,
                                         input epc_pkg::mat_t mt);
    epc_pkg::ctx_t r;
    logic signed [63:0] e [9];
    logic signed [epc_pkg::AW-1:0] w [epc_pkg::NPR];
    r = c;
    for (int i = 0; i < 9; i++) e[i] = 64'($signed(mt[i]));
    for (int i = 0; i < epc_pkg::NPR; i++) w[i] = epc_pkg::wid(epc_pkg::join_pp(c.pp[i]));
    case (k)
      0: begin
        r.pp[0] = epc_pkg::mul_pp(e[0], c.x2);
        r.pp[1] = epc_pkg::mul_pp(e[1], c.y2);
        r.pp[2] = epc_pkg::mul_pp(e[3], c.x2);
        r.pp[3] = epc_pkg::mul_pp(e[4], c.y2);
        r.pp[4] = epc_pkg::mul_pp(e[6], c.x2);
        r.pp[5] = epc_pkg::mul_pp(e[7], c.y2);
        r.pp[6] = epc_pkg::mul_pp(e[0], c.x1);
        r.pp[7] = epc_pkg::mul_pp(e[3], c.y1);
        r.pp[8] = epc_pkg::mul_pp(e[1], c.x1);
        r.pp[9] = epc_pkg::mul_pp(e[4], c.y1);
      end
      1: begin
        r.q0  = epc_pkg::rnd(w[0] + w[1] + epc_pkg::shl(e[2], FRAC_BITS), FRAC_BITS);
        r.q1  = epc_pkg::rnd(w[2] + w[3] + epc_pkg::shl(e[5], FRAC_BITS), FRAC_BITS);
        r.q2  = epc_pkg::rnd(w[4] + w[5] + epc_pkg::shl(e[8], FRAC_BITS), FRAC_BITS);
        r.n20 = epc_pkg::rnd(w[6] + w[7] + epc_pkg::shl(e[6], FRAC_BITS), FRAC_BITS);
        r.n21 = epc_pkg::rnd(w[8] + w[9] + epc_pkg::shl(e[7], FRAC_BITS), FRAC_BITS);
      end
      2: begin
        r.pp[0] = epc_pkg::mul_pp(c.x1, c.q0);
        r.pp[1] = epc_pkg::mul_pp(c.y1, c.q1);
        r.pp[2] = epc_pkg::mul_pp(e[0], c.n20);
        r.pp[3] = epc_pkg::mul_pp(e[1], c.n21);
        r.pp[4] = epc_pkg::mul_pp(e[3], c.n20);
        r.pp[5] = epc_pkg::mul_pp(e[4], c.n21);
        r.pp[6] = epc_pkg::mul_pp(c.q0, c.q0);
        r.pp[7] = epc_pkg::mul_pp(c.q1, c.q1);
        r.pp[8] = epc_pkg::mul_pp(c.n20, c.n20);
        r.pp[9] = epc_pkg::mul_pp(c.n21, c.n21);
      end
      3: begin
        r.qc  = epc_pkg::rnd(w[0] + w[1] + epc_pkg::shl(c.q2, FRAC_BITS), FRAC_BITS);
        r.tv0 = epc_pkg::rnd(w[2] + w[3], FRAC_BITS);
        r.tv1 = epc_pkg::rnd(w[4] + w[5], FRAC_BITS);
        // the 1/2 of b folds into the rounding shift
        r.qb  = epc_pkg::rnd(w[6] + w[7] + w[8] + w[9], FRAC_BITS + 1);
      end
      4: begin
        r.pp[0] = epc_pkg::mul_pp(c.q0, c.tv0);
        r.pp[1] = epc_pkg::mul_pp(c.q1, c.tv1);
        r.pp[2] = epc_pkg::mul_pp(c.qb, c.qb);
      end
      5: r.qa = epc_pkg::rnd(w[0] + w[1], FRAC_BITS);
      6: r.pp[3] = epc_pkg::mul_pp(c.qa, c.qc);
      7: r.disc = epc_pkg::join_pp(c.pp[2]) - epc_pkg::join_pp(c.pp[3]);
      8: begin
        if (c.root > epc_pkg::SAT_LIM) r.root = epc_pkg::SAT_LIM;
        r.dden = c.qb + r.root;
        r.pass = (r.dden <= 0);
        r.dnum = 128'(epc_pkg::shl(c.qc, FRAC_BITS));
      end
      9: begin
        r.pp[0] = epc_pkg::mul_pp(c.s, c.q0);
        r.pp[1] = epc_pkg::mul_pp(c.s, c.q1);
        r.pp[2] = epc_pkg::mul_pp(c.s, c.n20);
        r.pp[3] = epc_pkg::mul_pp(c.s, c.n21);
      end
      10: begin
        r.dx10 = epc_pkg::rnd(w[0], FRAC_BITS);
        r.dx11 = epc_pkg::rnd(w[1], FRAC_BITS);
        r.dx20 = epc_pkg::rnd(w[2], FRAC_BITS);
        r.dx21 = epc_pkg::rnd(w[3], FRAC_BITS);
      end
      11: begin
        // each normal is corrected with the other one
        r.pp[0] = epc_pkg::mul_pp(e[0], c.dx20);
        r.pp[1] = epc_pkg::mul_pp(e[1], c.dx21);
        r.pp[2] = epc_pkg::mul_pp(e[3], c.dx20);
        r.pp[3] = epc_pkg::mul_pp(e[4], c.dx21);
        r.pp[4] = epc_pkg::mul_pp(e[0], c.dx10);
        r.pp[5] = epc_pkg::mul_pp(e[3], c.dx11);
        r.pp[6] = epc_pkg::mul_pp(e[1], c.dx10);
        r.pp[7] = epc_pkg::mul_pp(e[4], c.dx11);
      end
      12: begin
        r.m10 = epc_pkg::rnd(epc_pkg::shl(c.q0, FRAC_BITS) - w[0] - w[1], FRAC_BITS);
        r.m11 = epc_pkg::rnd(epc_pkg::shl(c.q1, FRAC_BITS) - w[2] - w[3], FRAC_BITS);
        r.m20 = epc_pkg::rnd(epc_pkg::shl(c.n20, FRAC_BITS) - w[4] - w[5], FRAC_BITS);
        r.m21 = epc_pkg::rnd(epc_pkg::shl(c.n21, FRAC_BITS) - w[6] - w[7], FRAC_BITS);
      end
      13: begin
        r.pp[0] = epc_pkg::mul_pp(c.m10, c.m10);
        r.pp[1] = epc_pkg::mul_pp(c.m11, c.m11);
        r.pp[2] = epc_pkg::mul_pp(c.m20, c.m20);
        r.pp[3] = epc_pkg::mul_pp(c.m21, c.m21);
        r.pp[4] = epc_pkg::mul_pp(c.s, c.root);
      end
      14: begin
        r.den2 = epc_pkg::rnd(w[0] + w[1] + w[2] + w[3], FRAC_BITS);
        r.pass = c.pass | (r.den2 <= 0);
        r.dnum = epc_pkg::join_pp(c.pp[4]) + epc_pkg::join_pp(c.pp[4]);
        r.dden = r.den2;
      end
      15: begin
        r.pp[0] = epc_pkg::mul_pp(c.s2, c.m10);
        r.pp[1] = epc_pkg::mul_pp(c.s2, c.m11);
        r.pp[2] = epc_pkg::mul_pp(c.s2, c.m20);
        r.pp[3] = epc_pkg::mul_pp(c.s2, c.m21);
      end
      16: begin
        if (!c.pass) begin
          r.x1 = 64'(epc_pkg::clamp_coord(
                   epc_pkg::rnd(epc_pkg::shl(c.x1, FRAC_BITS) - w[0], FRAC_BITS)));
          r.y1 = 64'(epc_pkg::clamp_coord(
                   epc_pkg::rnd(epc_pkg::shl(c.y1, FRAC_BITS) - w[1], FRAC_BITS)));
          r.x2 = 64'(epc_pkg::clamp_coord(
                   epc_pkg::rnd(epc_pkg::shl(c.x2, FRAC_BITS) - w[2], FRAC_BITS)));
          r.y2 = 64'(epc_pkg::clamp_coord(
                   epc_pkg::rnd(epc_pkg::shl(c.y2, FRAC_BITS) - w[3], FRAC_BITS)));
        end
      end
      default: r = c;
    endcase
    return r;
  endfunction

  logic          vq [COUNT];
  epc_pkg::ctx_t cq [COUNT];

  for (genvar g = 0; g < COUNT; g++) begin : g_st
    logic          sv;
    epc_pkg::ctx_t sd;
    if (g == 0) begin : g_head
      assign sv = vin;
      assign sd = din;
    end else begin : g_body
      assign sv = vq[g-1];
      assign sd = cq[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[g] <= 1'b0;
      end else if (en) begin
        vq[g] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cq[g] <= step(FIRST + g, sd, mat);
      end
    end
  end

  assign vout = vq[COUNT-1];
  assign dout = cq[COUNT-1];

endmodule

`default_nettype wire

>>> design/epc_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a payload carried alongside.
// Depends on epc_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none

module epc_sqrt #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [127:0]  rad,
  input  logic [PW-1:0] pin,
  output logic          vout,
  output logic [63:0]   root,
  output logic [PW-1:0] pout
);

  localparam int N = epc_pkg::SQ_STEPS;

  logic          vq [N];
  logic [127:0]  rq [N];   // radicand minus root squared so far
  logic [N-1:0]  tq [N];
  logic [PW-1:0] pq [N];

  for (genvar g = 0; g < N; g++) begin : g_st
    localparam int B = N - 1 - g;
    logic          sv;
    logic [127:0]  srem;
    logic [N-1:0]  sr;
    logic [PW-1:0] sp;
    logic [127:0]  trial;

    if (g == 0) begin : g_head
      assign sv   = vin;
      assign srem = rad[127] ? '0 : rad;  // negative radicand roots to zero
      assign sr   = '0;
      assign sp   = pin;
    end else begin : g_body
      assign sv   = vq[g-1];
      assign srem = rq[g-1];
      assign sr   = tq[g-1];
      assign sp   = pq[g-1];
    end

    // (r + 2^B)^2 - r^2, r has no bits at or below B
    assign trial = (128'(sr) << (B + 1)) | (128'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[g] <= 1'b0;
      end else if (en) begin
        vq[g] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pq[g] <= sp;
        if (srem >= trial) begin
          rq[g] <= srem - trial;
          tq[g] <= sr | (N'(1) << B);
        end else begin
          rq[g] <= srem;
          tq[g] <= sr;
        end
      end
    end
  end

  assign vout = vq[N-1];
  assign root = 64'(tq[N-1]);
  assign pout = pq[N-1];

endmodule

`default_nettype wire

>>> design/epc_div.sv
// Pipelined rounded divider: 128-bit signed numerator over a positive 64-bit denominator,
// one quotient bit per stage, saturating. Depends on epc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epc_div #(
  parameter int PW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  logic signed [127:0] num,
  input  logic signed [63:0] den,
  input  logic [PW-1:0]      pin,
  output logic               vout,
  output logic signed [63:0] quot,
  output logic [PW-1:0]      pout
);

  localparam int N = epc_pkg::DIV_STEPS + 1;
  localparam int QW = epc_pkg::DIV_STEPS;

  logic          vq [N];
  logic          nq [N];
  logic          oq [N];
  logic [63:0]   dq [N];
  logic [127:0]  rq [N];
  logic [QW-1:0] qq [N];
  logic [PW-1:0] pq [N];

  logic [63:0]  d0;
  logic [127:0] mag0;

  // a zero or negative denominator only reaches here on a pass-through item
  assign d0   = (den <= 0) ? 64'd1 : den;
  assign mag0 = (num[127] ? 128'(-num) : 128'(num)) + 128'(d0 >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else if (en) begin
      vq[0] <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0] <= num[127];
      oq[0] <= (mag0 >= (128'(d0) << QW));
      dq[0] <= d0;
      rq[0] <= mag0;
      qq[0] <= '0;
      pq[0] <= pin;
    end
  end

  for (genvar g = 1; g < N; g++) begin : g_st
    localparam int B = QW - g;
    logic [127:0] sub;
    assign sub = 128'(dq[g-1]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[g] <= 1'b0;
      end else if (en) begin
        vq[g] <= vq[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[g] <= nq[g-1];
        oq[g] <= oq[g-1];
        dq[g] <= dq[g-1];
        pq[g] <= pq[g-1];
        if (rq[g-1] >= sub) begin
          rq[g] <= rq[g-1] - sub;
          qq[g] <= qq[g-1] | (QW'(1) << B);
        end else begin
          rq[g] <= rq[g-1];
          qq[g] <= qq[g-1];
        end
      end
    end
  end

  logic signed [63:0] qmag;
  assign qmag = oq[N-1] ? epc_pkg::SAT_LIM : $signed(64'(qq[N-1]));
  assign quot = nq[N-1] ? -qmag : qmag;
  assign vout = vq[N-1];
  assign pout = pq[N-1];

endmodule

`default_nettype wire

>>> design/epipolar_point_correction.sv
// Epipolar point correction, one closed-form iteration, as a single deep pipeline.
// Input channel in_valid/in_ready/in_item carries one correspondence (left and right
// point, signed fixed point). Output channel out_valid/out_ready/out_item returns the
// corrected points and a status bit (1 = degenerate, inputs passed through).
// The matrix is loaded through cfg_we/cfg_index/cfg_wdata, two entries per 64-bit
// register and the last entry alone; write it only while no item is in flight.
// The pipe holds 8 arithmetic stages, 63 root stages, 1 stage, 63 divider stages,
// 6 stages, a second 63-stage divider and 2 final stages; the last stage is the
// output register. One item is accepted every cycle unless the pipe holds.
// The whole pipe advances together: when out_ready is low with a result waiting, every
// stage holds and in_ready drops; empty stages are not squeezed out.
// Reset clears all stage valid bits and the matrix registers.
// Depends on epc_pkg, epc_stages, epc_sqrt, epc_div.
`timescale 1ns / 1ps
`default_nettype none

module epipolar_point_correction #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  epc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output epc_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  logic [63:0] e_pair_a, e_pair_b, e_pair_c, e_pair_d;
  logic [31:0] e_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_pair_a <= '0;
      e_pair_b <= '0;
      e_pair_c <= '0;
      e_pair_d <= '0;
      e_last   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        epc_pkg::REG_PAIR_A: e_pair_a <= cfg_wdata;
        epc_pkg::REG_PAIR_B: e_pair_b <= cfg_wdata;
        epc_pkg::REG_PAIR_C: e_pair_c <= cfg_wdata;
        epc_pkg::REG_PAIR_D: e_pair_d <= cfg_wdata;
        epc_pkg::REG_LAST:   e_last   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  epc_pkg::mat_t mat;
  assign mat = {e_last, e_pair_d, e_pair_c, e_pair_b, e_pair_a};

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  epc_pkg::ctx_t c_in;
  always_comb begin
    c_in    = '0;
    c_in.x1 = 64'(in_item.left_x);
    c_in.y1 = 64'(in_item.left_y);
    c_in.x2 = 64'(in_item.right_x);
    c_in.y2 = 64'(in_item.right_y);
  end

  localparam int PW = $bits(epc_pkg::ctx_t);

  logic          v_a, v_s, v_b, v_d1, v_c, v_d2, v_o;
  epc_pkg::ctx_t c_a, c_s, c_s2, c_b, c_d1, c_d1s, c_c, c_d2, c_d2s, c_o;
  logic [63:0]        root;
  logic signed [63:0] s_q, s2_q;

  epc_stages #(.FIRST(0), .COUNT(8), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(adv), .vin(in_valid && in_ready), .din(c_in), .mat(mat),
    .vout(v_a), .dout(c_a)
  );

  epc_sqrt #(.PW(PW)) u_sqrt (
    .clk(clk), .rst(rst), .en(adv), .vin(v_a), .rad(c_a.disc), .pin(c_a),
    .vout(v_s), .root(root), .pout(c_s)
  );

  always_comb begin
    c_s2      = c_s;
    c_s2.root = $signed(root);
  end

  epc_stages #(.FIRST(8), .COUNT(1), .FRAC_BITS(FRAC_BITS)) u_den1 (
    .clk(clk), .rst(rst), .en(adv), .vin(v_s), .din(c_s2), .mat(mat),
    .vout(v_b), .dout(c_b)
  );

  epc_div #(.PW(PW)) u_div1 (
    .clk(clk), .rst(rst), .en(adv), .vin(v_b), .num(c_b.dnum), .den(c_b.dden), .pin(c_b),
    .vout(v_d1), .quot(s_q), .pout(c_d1)
  );

  always_comb begin
    c_d1s   = c_d1;
    c_d1s.s = s_q;
  end

  epc_stages #(.FIRST(9), .COUNT(6), .FRAC_BITS(FRAC_BITS)) u_mid (
    .clk(clk), .rst(rst), .en(adv), .vin(v_d1), .din(c_d1s), .mat(mat),
    .vout(v_c), .dout(c_c)
  );

  epc_div #(.PW(PW)) u_div2 (
    .clk(clk), .rst(rst), .en(adv), .vin(v_c), .num(c_c.dnum), .den(c_c.dden), .pin(c_c),
    .vout(v_d2), .quot(s2_q), .pout(c_d2)
  );

  always_comb begin
    c_d2s    = c_d2;
    c_d2s.s2 = s2_q;
  end

  epc_stages #(.FIRST(15), .COUNT(2), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .en(adv), .vin(v_d2), .din(c_d2s), .mat(mat),
    .vout(v_o), .dout(c_o)
  );

  assign out_valid              = v_o;
  assign out_item.fixed_left_x  = c_o.x1[epc_pkg::COORD_W-1:0];
  assign out_item.fixed_left_y  = c_o.y1[epc_pkg::COORD_W-1:0];
  assign out_item.fixed_right_x = c_o.x2[epc_pkg::COORD_W-1:0];
  assign out_item.fixed_right_y = c_o.y2[epc_pkg::COORD_W-1:0];
  assign out_item.status        = c_o.pass;

endmodule

`default_nettype wire

>>> design/epc_checker.sv
// Port-level checks for the epipolar point correction block, bound to the top level.
// Depends on epc_pkg and epipolar_point_correction.
`timescale 1ns / 1ps
`default_nettype none

module epc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input epc_pkg::out_item_t out_item
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // the pipe accepts exactly when its last stage can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stage");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output item valid after reset");

endmodule

bind epipolar_point_correction epc_checker u_epc_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item(out_item)
);

`default_nettype wire

>>> bench/tb_epipolar_point_correction.sv
// Self-checking bench for epipolar_point_correction: directed and random correspondences
// against a bit-exact predictor of the one-iteration correction. Depends on epc_pkg and epipolar_point_correction.
`timescale 1ns / 1ps

module tb_epipolar_point_correction;

  typedef logic signed [129:0] wide_t;
  typedef logic signed [63:0]  s64_t;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // above the last register, ignored
  localparam s64_t ONE = 64'sd1 <<< 24;
  localparam int   LAT = 206;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  epc_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  epc_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  logic [63:0] mat_regs [5];
  epc_pkg::in_item_t  pending_q [$];
  epc_pkg::out_item_t expected_q [$];
  int errors = 0;
  bit quiet = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;

  epipolar_point_correction dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic wide_t mw(input s64_t a, input s64_t b);
    wide_t x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  // add half an LSB, floor, saturate to +-(2^62-1)
  function automatic s64_t round_sat(input wide_t x, input int sh);
    wide_t h, t, lim;
    h = 1;
    h = h <<< (sh - 1);
    t = (x + h) >>> sh;
    lim = epc_pkg::SAT_LIM;
    if (t > lim) return epc_pkg::SAT_LIM;
    if (t < -lim) return epc_pkg::NEG_LIM;
    return t[63:0];
  endfunction

  // nearest, half away from zero; den > 0
  function automatic s64_t div_near(input wide_t num, input s64_t den);
    logic [129:0] m, d, q;
    s64_t mag;
    m = (num < 0) ? -num : num;
    d = den;
    m = m + (d >> 1);
    q = m / d;
    mag = (q > epc_pkg::SAT_LIM) ? epc_pkg::SAT_LIM : q[63:0];
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic s64_t root_floor(input wide_t v);
    s64_t r, t;
    r = 0;
    if (v < 0) return 0;
    for (int b = 62; b >= 0; b--) begin
      t = r | (64'sd1 <<< b);
      if (mw(t, t) <= v) r = t;
    end
    return (r > epc_pkg::SAT_LIM) ? epc_pkg::SAT_LIM : r;
  endfunction

  function automatic logic signed [31:0] sat_coord(input s64_t v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic epc_pkg::out_item_t correct_points(input epc_pkg::in_item_t it);
    s64_t em [3][3];
    s64_t p1 [3], p2 [3], q [3], n1 [2], n2 [2], tv [2], dx1 [2], dx2 [2], m1 [2], m2 [2];
    s64_t qa, qb, qc, root, den1, den2, s, s2;
    wide_t acc;
    epc_pkg::out_item_t r;
    em[0][0] = $signed(mat_regs[0][31:0]); em[0][1] = $signed(mat_regs[0][63:32]);
    em[0][2] = $signed(mat_regs[1][31:0]); em[1][0] = $signed(mat_regs[1][63:32]);
    em[1][1] = $signed(mat_regs[2][31:0]); em[1][2] = $signed(mat_regs[2][63:32]);
    em[2][0] = $signed(mat_regs[3][31:0]); em[2][1] = $signed(mat_regs[3][63:32]);
    em[2][2] = $signed(mat_regs[4][31:0]);
    p1[0] = it.left_x;  p1[1] = it.left_y;  p1[2] = ONE;
    p2[0] = it.right_x; p2[1] = it.right_y; p2[2] = ONE;
    for (int i = 0; i < 3; i++)
      q[i] = round_sat(mw(em[i][0], p2[0]) + mw(em[i][1], p2[1]) + mw(em[i][2], p2[2]), 24);
    n1[0] = q[0];
    n1[1] = q[1];
    for (int j = 0; j < 2; j++)
      n2[j] = round_sat(mw(em[0][j], p1[0]) + mw(em[1][j], p1[1]) + mw(em[2][j], p1[2]), 24);
    qc = round_sat(mw(p1[0], q[0]) + mw(p1[1], q[1]) + mw(p1[2], q[2]), 24);
    for (int i = 0; i < 2; i++)
      tv[i] = round_sat(mw(em[i][0], n2[0]) + mw(em[i][1], n2[1]), 24);
    qa = round_sat(mw(n1[0], tv[0]) + mw(n1[1], tv[1]), 24);
    qb = round_sat(mw(n1[0], n1[0]) + mw(n1[1], n1[1]) + mw(n2[0], n2[0])
                   + mw(n2[1], n2[1]), 25);
    root = root_floor(mw(qb, qb) - mw(qa, qc));
    r.fixed_left_x  = it.left_x;
    r.fixed_left_y  = it.left_y;
    r.fixed_right_x = it.right_x;
    r.fixed_right_y = it.right_y;
    r.status = 1'b1;
    den1 = qb + root;
    if (den1 <= 0) return r;
    s = div_near(mw(qc, ONE), den1);
    for (int i = 0; i < 2; i++) begin
      dx1[i] = round_sat(mw(s, n1[i]), 24);
      dx2[i] = round_sat(mw(s, n2[i]), 24);
    end
    // each normal is updated with the other, old normal
    for (int i = 0; i < 2; i++) begin
      m1[i] = round_sat(mw(n1[i], ONE) - mw(em[i][0], dx2[0]) - mw(em[i][1], dx2[1]), 24);
      m2[i] = round_sat(mw(n2[i], ONE) - mw(em[0][i], dx1[0]) - mw(em[1][i], dx1[1]), 24);
    end
    den2 = round_sat(mw(m1[0], m1[0]) + mw(m1[1], m1[1]) + mw(m2[0], m2[0])
                     + mw(m2[1], m2[1]), 24);
    if (den2 <= 0) return r;
    acc = mw(s, root);
    s2 = div_near(acc + acc, den2);
    r.fixed_left_x  = sat_coord(round_sat(mw(p1[0], ONE) - mw(s2, m1[0]), 24));
    r.fixed_left_y  = sat_coord(round_sat(mw(p1[1], ONE) - mw(s2, m1[1]), 24));
    r.fixed_right_x = sat_coord(round_sat(mw(p2[0], ONE) - mw(s2, m2[0]), 24));
    r.fixed_right_y = sat_coord(round_sat(mw(p2[1], ONE) - mw(s2, m2[1]), 24));
    r.status = 1'b0;
    return r;
  endfunction

  // source side: one item per handshake, random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) expected_q.push_back(correct_points(in_item));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_item <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sink side: check each result against the oldest expectation
  always @(posedge clk) begin
    epc_pkg::out_item_t e;
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected item %h", out_item);
        end else begin
          e = expected_q.pop_front();
          if (out_item !== e) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: exp lx=%h ly=%h rx=%h ry=%h st=%b got lx=%h ly=%h rx=%h ry=%h st=%b",
                       e.fixed_left_x, e.fixed_left_y, e.fixed_right_x, e.fixed_right_y,
                       e.status, out_item.fixed_left_x, out_item.fixed_left_y,
                       out_item.fixed_right_x, out_item.fixed_right_y, out_item.status);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx <= epc_pkg::REG_LAST)
      mat_regs[idx] = (idx == epc_pkg::REG_LAST) ? {32'h0, val[31:0]} : val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(input logic [31:0] m [9]);
    write_reg(epc_pkg::REG_PAIR_A, {m[1], m[0]});
    write_reg(epc_pkg::REG_PAIR_B, {m[3], m[2]});
    write_reg(epc_pkg::REG_PAIR_C, {m[5], m[4]});
    write_reg(epc_pkg::REG_PAIR_D, {m[7], m[6]});
    write_reg(epc_pkg::REG_LAST, {$urandom(), m[8]});
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry(input int span);
    case ($urandom_range(0, 11))
      0: return 32'h0;
      1: return $urandom();
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  function automatic epc_pkg::in_item_t pt(input logic [31:0] a, b, c, d);
    epc_pkg::in_item_t t;
    t.left_x = a; t.left_y = b; t.right_x = c; t.right_y = d;
    return t;
  endfunction

  initial begin
    logic [31:0] m [9];
    int span;
    foreach (mat_regs[i]) mat_regs[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero matrix after reset: every item degenerate, passed through
    pending_q.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF));
    pending_q.push_back(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    pending_q.push_back(pt(32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 32'h0));
    pending_q.push_back(pt(32'h0, 32'h0, 32'h0, 32'h0));
    drain();

    // pure translation essential matrix (skew of t = (1, 0.5, 0.25))
    m = '{32'h0, 32'hFFC0_0000, 32'h0080_0000, 32'h0040_0000, 32'h0,
          32'hFF00_0000, 32'hFF80_0000, 32'h0100_0000, 32'h0};
    load_matrix(m);
    write_reg(REG_UNUSED, 64'hDEAD_BEEF_1234_5678);
    pending_q.push_back(pt(32'h0100_0000, 32'h0200_0000, 32'h0100_0000, 32'h0200_0000));
    pending_q.push_back(pt(32'h0100_0000, 32'h0, 32'h0, 32'h0100_0000));
    pending_q.push_back(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_q.push_back(pt(32'h0, 32'h0, 32'h0, 32'h0));
    pending_q.push_back(pt(32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF));
    pending_q.push_back(pt(32'h0400_0000, 32'hFC00_0000, 32'h0200_0000, 32'h0300_0000));
    // negative discriminant: points far from the epipolar line
    pending_q.push_back(pt(32'h0F00_0000, 32'hF100_0000, 32'hF000_0000, 32'h0E00_0000));
    drain();

    // register extremes
    write_reg(epc_pkg::REG_PAIR_A, 64'h7FFF_FFFF_8000_0000);
    write_reg(epc_pkg::REG_PAIR_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(epc_pkg::REG_PAIR_C, 64'h8000_0000_7FFF_FFFF);
    write_reg(epc_pkg::REG_PAIR_D, 64'h0000_0001_7FFF_FFFF);
    write_reg(epc_pkg::REG_LAST, 64'h0000_0000_8000_0000);
    pending_q.push_back(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_q.push_back(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_q.push_back(pt(32'h0, 32'h0, 32'h0, 32'h0));
    pending_q.push_back(pt(32'h0100_0000, 32'hFF00_0000, 32'h0100_0000, 32'hFF00_0000));
    drain();

    // random matrices at several scales, the last phase with no idling
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 3)
        0: span = 32'h0200_0000;
        1: span = 32'h4000_0000;
        default: span = 32'h0040_0000;
      endcase
      foreach (m[i]) m[i] = rand_entry(span);
      load_matrix(m);
      quiet = (ph == 8);
      for (int k = 0; k < 150; k++)
        pending_q.push_back(pt(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
      drain();
    end

    repeat (LAT) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
